FILE: design/altr_pkg.sv
`timescale 1ns / 1ps
// altr_pkg: shared constants, fit status codes and sequencer states
// for the altitude trend regression block; no dependencies
package altr_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int TIME_BITS_DEF   = 24;
  localparam int TS_W            = 48;
  localparam int ALT_W           = 24;
  localparam int SLOPE_W         = 32;
  localparam int SCALE           = 256000000;
  localparam int SCALE_W         = 28;
  localparam int MIN_FIT         = 2;

  typedef enum logic [1:0] {
    FIT_OK         = 2'd0,
    FIT_NOT_READY  = 2'd1,
    FIT_DEGENERATE = 2'd2
  } fit_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_TT,
    ST_MUL_TH,
    ST_FIT,
    ST_MUL_A,
    ST_MUL_B,
    ST_DEN_CHK,
    ST_MUL_C,
    ST_MUL_D,
    ST_NUM_ABS,
    ST_MUL_E,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

FILE: design/altr_mul.sv
`timescale 1ns / 1ps
// altr_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// signed multiplicand times unsigned multiplier, product modulo 2^PW; no dependencies
module altr_mul #(
  parameter int PW = 100,
  parameter int MW = 35
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] mcand,
  input  logic [MW-1:0] mplier,
  output logic [PW-1:0] product,
  output logic          done
);

  localparam int CNT_W = $clog2(MW + 1);

  logic [PW-1:0]    acc;
  logic [PW-1:0]    mc;
  logic [MW-1:0]    mp;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mc  <= mcand;
      mp  <= mplier;
    end else if (busy) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= {mc[PW-2:0], 1'b0};
      mp <= {1'b0, mp[MW-1:1]};
    end
  end

  assign product = acc;

endmodule

FILE: design/altr_div.sv
`timescale 1ns / 1ps
// altr_div: restoring divider, one quotient bit per cycle
// keeps the low quotient bits plus a sticky overflow flag; uses altr_pkg
module altr_div #(
  parameter int NW = 99,
  parameter int DW = 71
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NW-1:0]            numer,
  input  logic [DW-2:0]            denom,
  output logic [altr_pkg::SLOPE_W:0] quot,
  output logic                     ovf,
  output logic                     done
);

  localparam int QW    = altr_pkg::SLOPE_W + 1;
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    ns;
  logic [DW-1:0]    rem;
  logic [DW-2:0]    dv;
  logic [QW-1:0]    q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW-1:0]    rem_sh;
  logic             ge;

  assign rem_sh = {rem[DW-2:0], ns[NW-1]};
  assign ge     = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ns  <= numer;
      dv  <= denom;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      ns  <= {ns[NW-2:0], 1'b0};
      rem <= ge ? (rem_sh - {1'b0, dv}) : rem_sh;
      q   <= {q[QW-2:0], ge};
      ovf <= ovf | q[QW-1];
    end
  end

  assign quot = q;

endmodule

FILE: design/altitude_trend_regression.sv
`timescale 1ns / 1ps
// altitude_trend_regression: windowed least-squares altitude slope and span
// depends on altr_pkg, altr_mul, altr_div
//
// channel  dir  tdata                                tuser
// s_axis   in   time_us, altitude_cm                 restart, sample_ok
// m_axis   out  slope, span_cm, sample_count         accepted, fit_status
//
// each multiply runs on the shared bit-serial multiplier over MW multiplier bits
// (MW = max(count bits + TIME_BITS, 28)), the divide on the one-bit-a-cycle divider
// whose numerator comes from the multiplier product of PW bits (PW = product width)
// accepted sample: accept, check, the two sum multiplies, then the fit multiplies,
// the divide and done; a rejected sample skips the sum multiplies,
// a window below two samples or a degenerate denominator skips the rest of the fit
// one item at a time; a new transaction is taken while the last result waits
// rst clears the window and control; a stalled result holds the sequencer in done
module altitude_trend_regression #(
  parameter int MAX_SAMPLES = altr_pkg::MAX_SAMPLES_DEF,
  parameter int TIME_BITS   = altr_pkg::TIME_BITS_DEF,
  parameter int CW          = $clog2(MAX_SAMPLES + 1),
  parameter int OD_W        = ((altr_pkg::SLOPE_W + altr_pkg::ALT_W + CW + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [71:0]     s_tdata,   // time_us[47:0], altitude_cm[71:48]
  input  logic [1:0]      s_tuser,   // restart[0], sample_ok[1]
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [OD_W-1:0] m_tdata,   // slope[31:0], span_cm[55:32], sample_count, zero pad
  output logic [2:0]      m_tuser    // accepted[0], fit_status[2:1]
);

  localparam int TS_W    = altr_pkg::TS_W;
  localparam int ALT_W   = altr_pkg::ALT_W;
  localparam int SLOPE_W = altr_pkg::SLOPE_W;
  localparam int ST_W    = CW + TIME_BITS;
  localparam int SH_W    = CW + ALT_W;
  localparam int STT_W   = CW + 2 * TIME_BITS;
  localparam int STH_W   = CW + TIME_BITS + ALT_W;
  localparam int PW      = 2 * CW + TIME_BITS + ALT_W + altr_pkg::SCALE_W + 2;
  localparam int DW      = 2 * CW + 2 * TIME_BITS + 1;
  localparam int MW      = (ST_W > altr_pkg::SCALE_W) ? ST_W : altr_pkg::SCALE_W;
  localparam int QW      = SLOPE_W + 1;
  localparam int PAD_W   = OD_W - SLOPE_W - ALT_W - CW;

  altr_pkg::state_t state, state_next;
  logic fresh;

  // captured transaction
  logic                    in_restart;
  logic                    in_ok;
  logic [TS_W-1:0]         in_ts;
  logic signed [ALT_W-1:0] in_alt;

  // window state
  logic [CW-1:0]           count;
  logic [TS_W-1:0]         first_time;
  logic [TS_W-1:0]         last_time;
  logic [ST_W-1:0]         sum_time;
  logic signed [SH_W-1:0]  sum_height;
  logic [STT_W-1:0]        sum_tt;
  logic signed [STH_W-1:0] sum_th;
  logic signed [ALT_W-1:0] min_h;
  logic signed [ALT_W-1:0] max_h;

  // work registers
  logic [TIME_BITS-1:0]    t_reg;
  logic                    acc_flag;
  logic [DW-1:0]           den;
  logic [PW-1:0]           num;
  logic                    num_neg;
  altr_pkg::fit_status_t   res_status;
  logic [SLOPE_W-1:0]      res_slope;

  // output register
  logic                    out_acc;
  altr_pkg::fit_status_t   out_status;
  logic [SLOPE_W-1:0]      out_slope;
  logic [ALT_W-1:0]        out_span;
  logic [CW-1:0]           out_count;

  // admission check on the window as seen after a restart
  logic [CW-1:0]           cnt_b;
  logic [TS_W-1:0]         first_b, last_b, dt;
  logic [ST_W-1:0]         st_b;
  logic signed [SH_W-1:0]  sh_b;
  logic [STT_W-1:0]        stt_b;
  logic signed [STH_W-1:0] sth_b;
  logic signed [ALT_W-1:0] min_b, max_b;
  logic                    acc_c;
  logic [TIME_BITS-1:0]    t_c;

  always_comb begin
    cnt_b   = in_restart ? '0 : count;
    first_b = in_restart ? '0 : first_time;
    last_b  = in_restart ? '0 : last_time;
    st_b    = in_restart ? '0 : sum_time;
    sh_b    = in_restart ? '0 : sum_height;
    stt_b   = in_restart ? '0 : sum_tt;
    sth_b   = in_restart ? '0 : sum_th;
    min_b   = in_restart ? '0 : min_h;
    max_b   = in_restart ? '0 : max_h;
    dt      = in_ts - first_b;
    acc_c   = in_ok && (in_ts != '0) && (cnt_b < CW'(MAX_SAMPLES)) &&
              ((cnt_b == '0) || ((in_ts > last_b) && !(|dt[TS_W-1:TIME_BITS])));
    t_c     = (cnt_b == '0) ? '0 : dt[TIME_BITS-1:0];
  end

  // shared units
  logic          mul_start, mul_done;
  logic [PW-1:0] mul_a, mul_p;
  logic [MW-1:0] mul_b;
  logic          div_start, div_done, div_ovf;
  logic [QW-1:0] div_q;

  altr_mul #(.PW(PW), .MW(MW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .product (mul_p),
    .done    (mul_done)
  );

  altr_div #(.NW(PW - 1), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (num[PW-2:0]),
    .denom (den[DW-2:0]),
    .quot  (div_q),
    .ovf   (div_ovf),
    .done  (div_done)
  );

  logic den_bad;
  logic out_free;
  assign den_bad  = den[DW-1] || (den == '0);
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      altr_pkg::ST_IDLE:    if (s_tvalid) state_next = altr_pkg::ST_CHECK;
      altr_pkg::ST_CHECK:   state_next = acc_c ? altr_pkg::ST_MUL_TT : altr_pkg::ST_FIT;
      altr_pkg::ST_MUL_TT:  if (mul_done) state_next = altr_pkg::ST_MUL_TH;
      altr_pkg::ST_MUL_TH:  if (mul_done) state_next = altr_pkg::ST_FIT;
      altr_pkg::ST_FIT: begin
        state_next = (count < CW'(altr_pkg::MIN_FIT)) ? altr_pkg::ST_DONE : altr_pkg::ST_MUL_A;
      end
      altr_pkg::ST_MUL_A:   if (mul_done) state_next = altr_pkg::ST_MUL_B;
      altr_pkg::ST_MUL_B:   if (mul_done) state_next = altr_pkg::ST_DEN_CHK;
      altr_pkg::ST_DEN_CHK: state_next = den_bad ? altr_pkg::ST_DONE : altr_pkg::ST_MUL_C;
      altr_pkg::ST_MUL_C:   if (mul_done) state_next = altr_pkg::ST_MUL_D;
      altr_pkg::ST_MUL_D:   if (mul_done) state_next = altr_pkg::ST_NUM_ABS;
      altr_pkg::ST_NUM_ABS: state_next = altr_pkg::ST_MUL_E;
      altr_pkg::ST_MUL_E:   if (mul_done) state_next = altr_pkg::ST_DIV;
      altr_pkg::ST_DIV:     if (div_done) state_next = altr_pkg::ST_DONE;
      altr_pkg::ST_DONE:    if (out_free) state_next = altr_pkg::ST_IDLE;
      default:              state_next = altr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = (state == altr_pkg::ST_IDLE);
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = fresh && (state == altr_pkg::ST_DIV);
    case (state)
      altr_pkg::ST_MUL_TT: begin
        mul_start = fresh;
        mul_a     = PW'(t_reg);
        mul_b     = MW'(t_reg);
      end
      altr_pkg::ST_MUL_TH: begin
        mul_start = fresh;
        mul_a     = {{(PW - ALT_W){in_alt[ALT_W-1]}}, in_alt};
        mul_b     = MW'(t_reg);
      end
      altr_pkg::ST_MUL_A: begin
        mul_start = fresh;
        mul_a     = PW'(sum_tt);
        mul_b     = MW'(count);
      end
      altr_pkg::ST_MUL_B: begin
        mul_start = fresh;
        mul_a     = PW'(sum_time);
        mul_b     = MW'(sum_time);
      end
      altr_pkg::ST_MUL_C: begin
        mul_start = fresh;
        mul_a     = {{(PW - STH_W){sum_th[STH_W-1]}}, sum_th};
        mul_b     = MW'(count);
      end
      altr_pkg::ST_MUL_D: begin
        mul_start = fresh;
        mul_a     = {{(PW - SH_W){sum_height[SH_W-1]}}, sum_height};
        mul_b     = MW'(sum_time);
      end
      altr_pkg::ST_MUL_E: begin
        mul_start = fresh;
        mul_a     = num;
        mul_b     = MW'(altr_pkg::SCALE);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= altr_pkg::ST_IDLE;
      fresh <= 1'b0;
    end else begin
      state <= state_next;
      fresh <= (state_next != state);
    end
  end

  // slope from the quotient, saturated
  logic [QW-1:0]      lim;
  logic               sat;
  logic [SLOPE_W-1:0] mag;
  always_comb begin
    lim = {1'b0, num_neg, {(SLOPE_W - 1){~num_neg}}};
    sat = div_ovf || (div_q > lim);
    mag = sat ? lim[SLOPE_W-1:0] : div_q[SLOPE_W-1:0];
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      first_time <= '0;
      last_time  <= '0;
      sum_time   <= '0;
      sum_height <= '0;
      sum_tt     <= '0;
      sum_th     <= '0;
      min_h      <= '0;
      max_h      <= '0;
    end else begin
      case (state)
        altr_pkg::ST_CHECK: begin
          count      <= acc_c ? cnt_b + CW'(1) : cnt_b;
          first_time <= (acc_c && cnt_b == '0) ? in_ts : first_b;
          last_time  <= acc_c ? in_ts : last_b;
          sum_time   <= acc_c ? st_b + ST_W'(t_c) : st_b;
          sum_height <= acc_c ? sh_b + SH_W'(in_alt) : sh_b;
          sum_tt     <= stt_b;
          sum_th     <= sth_b;
          if (acc_c && cnt_b == '0) begin
            min_h <= in_alt;
            max_h <= in_alt;
          end else if (acc_c) begin
            min_h <= (in_alt < min_b) ? in_alt : min_b;
            max_h <= (in_alt > max_b) ? in_alt : max_b;
          end else begin
            min_h <= min_b;
            max_h <= max_b;
          end
        end
        altr_pkg::ST_MUL_TT: if (mul_done) sum_tt <= sum_tt + mul_p[STT_W-1:0];
        altr_pkg::ST_MUL_TH: if (mul_done) sum_th <= sum_th + mul_p[STH_W-1:0];
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // captured transaction and fit work registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_restart <= s_tuser[0];
      in_ok      <= s_tuser[1];
      in_ts      <= s_tdata[TS_W-1:0];
      in_alt     <= s_tdata[TS_W +: ALT_W];
    end
    case (state)
      altr_pkg::ST_CHECK: begin
        t_reg    <= t_c;
        acc_flag <= acc_c;
      end
      altr_pkg::ST_FIT: begin
        res_status <= altr_pkg::FIT_NOT_READY;
        res_slope  <= '0;
      end
      altr_pkg::ST_MUL_A: if (mul_done) den <= mul_p[DW-1:0];
      altr_pkg::ST_MUL_B: if (mul_done) den <= den - mul_p[DW-1:0];
      altr_pkg::ST_DEN_CHK: begin
        res_status <= altr_pkg::FIT_DEGENERATE;
        res_slope  <= '0;
      end
      altr_pkg::ST_MUL_C: if (mul_done) num <= mul_p;
      altr_pkg::ST_MUL_D: if (mul_done) num <= num - mul_p;
      altr_pkg::ST_NUM_ABS: begin
        num_neg <= num[PW-1];
        num     <= num[PW-1] ? (PW'(0) - num) : num;
      end
      altr_pkg::ST_MUL_E: if (mul_done) num <= mul_p;
      altr_pkg::ST_DIV: begin
        if (div_done) begin
          res_status <= altr_pkg::FIT_OK;
          res_slope  <= num_neg ? (SLOPE_W'(0) - mag) : mag;
        end
      end
      default: begin
        t_reg <= t_reg;
      end
    endcase
  end

  // result register
  logic out_load;
  assign out_load = (state == altr_pkg::ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_acc    <= acc_flag;
      out_status <= res_status;
      out_slope  <= res_slope;
      out_span   <= max_h - min_h;
      out_count  <= count;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_count, out_span, out_slope};
  assign m_tuser = {out_status, out_acc};

`ifndef SYNTHESIS
  a_acc_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_acc |-> out_count != '0)
    else $error("accepted sample reported with an empty window");

  a_ok_two_samples: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status == altr_pkg::FIT_OK |-> out_count >= CW'(altr_pkg::MIN_FIT))
    else $error("fit reported ok below two samples");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == altr_pkg::ST_DIV)
    else $error("divider finished outside the divide step");
`endif

endmodule
